/* design/fpc_pkg.sv */
// Shared types and constants for the frustum plane classifier.
`timescale 1ns / 1ps
package fpc_pkg;

  localparam int PLANE_COUNT   = 6;
  localparam int PLANE_W       = 64;
  localparam int COORD_W       = 16;
  localparam int PACK_W        = 48;
  localparam int CFG_IDX_W     = 3;
  localparam int QUEUE_DEPTH_D = 8;
  // Number of register stages in the arithmetic pipe.
  localparam int FRONT_STAGES  = 4;

  typedef enum logic [1:0] {
    CLS_BACK     = 2'd0,
    CLS_FRONT    = 2'd1,
    CLS_ON_PLANE = 2'd2,
    CLS_SPANNING = 2'd3
  } cls_t;

  typedef enum logic {
    OP_POINT = 1'b0,
    OP_BOX   = 1'b1
  } op_t;

  // Per-plane verdicts handed from the arithmetic pipe to the resolver.
  typedef struct packed {
    op_t                    op;
    logic [PLANE_COUNT-1:0] dist_zero;
    logic [PLANE_COUNT-1:0] dist_neg;
    logic [PLANE_COUNT-1:0] box_back;
  } entry_t;

endpackage

/* design/fpc_front.sv */
// Arithmetic pipe: plane distances and box radii, reduced to per-plane flags.
`timescale 1ns / 1ps
module fpc_front
  import fpc_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [PLANE_COUNT-1:0][PLANE_W-1:0] planes,
  input  logic                              in_take,
  input  logic                              in_op,
  input  logic signed [COORD_W-1:0]         in_center_x,
  input  logic signed [COORD_W-1:0]         in_center_y,
  input  logic signed [COORD_W-1:0]         in_center_z,
  input  logic [PACK_W-1:0]                 in_axis_zero,
  input  logic [PACK_W-1:0]                 in_axis_one,
  input  logic [PACK_W-1:0]                 in_axis_two,
  input  logic [PACK_W-1:0]                 in_extents,
  output logic [$clog2(FRONT_STAGES+1)-1:0] busy_cnt,
  output logic                              push,
  output entry_t                            push_entry
);

  // Stage 1: centre products and scaled half axes
  logic                     v1_r;
  op_t                      op1_r;
  logic signed [31:0]       cp1_r [PLANE_COUNT][3];
  logic signed [31:0]       h1_r  [3][3];
  // Stage 2: centre distance and axis projections
  logic                     v2_r;
  op_t                      op2_r;
  logic signed [33:0]       dist2_r [PLANE_COUNT];
  logic signed [47:0]       pp2_r   [PLANE_COUNT][3][3];
  // Stage 3: absolute projections
  logic                     v3_r;
  op_t                      op3_r;
  logic signed [33:0]       dist3_r [PLANE_COUNT];
  logic [47:0]              ab3_r   [PLANE_COUNT][3];
  // Stage 4: flags
  logic                     v4_r;
  entry_t                   ent4_r;
  entry_t                   ent4_nxt;

  logic [2:0][PACK_W-1:0]   axes;
  assign axes[0] = in_axis_zero;
  assign axes[1] = in_axis_one;
  assign axes[2] = in_axis_two;

  // Track valid items in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_take;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Stage 1 products
  always_ff @(posedge clk) begin
    op1_r <= op_t'(in_op);
    for (int p = 0; p < PLANE_COUNT; p++) begin
      cp1_r[p][0] <= $signed(planes[p][15:0])  * in_center_x;
      cp1_r[p][1] <= $signed(planes[p][31:16]) * in_center_y;
      cp1_r[p][2] <= $signed(planes[p][47:32]) * in_center_z;
    end
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        h1_r[i][k] <= $signed(axes[i][16*k +: 16]) * $signed(in_extents[16*i +: 16]);
      end
    end
  end

  // Stage 2 distance sum and projection products
  always_ff @(posedge clk) begin
    op2_r <= op1_r;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      dist2_r[p] <= 34'(cp1_r[p][0]) + 34'(cp1_r[p][1]) + 34'(cp1_r[p][2])
                  + 34'($signed({planes[p][63:48], 14'b0}));
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          pp2_r[p][i][k] <= $signed(planes[p][16*k +: 16]) * h1_r[i][k];
        end
      end
    end
  end

  // Stage 3 projection sums, take magnitude
  always_ff @(posedge clk) begin
    op3_r <= op2_r;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      dist3_r[p] <= dist2_r[p];
      for (int i = 0; i < 3; i++) begin
        logic signed [47:0] s;
        s = pp2_r[p][i][0] + pp2_r[p][i][1] + pp2_r[p][i][2];
        ab3_r[p][i] <= s[47] ? 48'(-s) : 48'(s);
      end
    end
  end

  // Stage 4 compares
  always_comb begin
    ent4_nxt.op = op3_r;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      logic [49:0]        radius;
      logic signed [51:0] t;
      radius = 50'(ab3_r[p][0]) + 50'(ab3_r[p][1]) + 50'(ab3_r[p][2]);
      t = 52'($signed({dist3_r[p], 14'b0})) + $signed({2'b00, radius});
      ent4_nxt.dist_zero[p] = (dist3_r[p] == '0);
      ent4_nxt.dist_neg[p]  = dist3_r[p][33];
      ent4_nxt.box_back[p]  = t[51] | (t == '0);
    end
  end

  always_ff @(posedge clk) begin
    ent4_r <= ent4_nxt;
  end

  assign push       = v4_r;
  assign push_entry = ent4_r;
  assign busy_cnt   = ($clog2(FRONT_STAGES+1))'(v1_r) + ($clog2(FRONT_STAGES+1))'(v2_r)
                    + ($clog2(FRONT_STAGES+1))'(v3_r) + ($clog2(FRONT_STAGES+1))'(v4_r);

endmodule

/* design/fpc_queue.sv */
// Small FIFO between the arithmetic pipe and the resolver.
`timescale 1ns / 1ps
module fpc_queue
  import fpc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_D
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  entry_t                     push_entry,
  input  logic                       pop,
  output logic                       not_empty,
  output entry_t                     head,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_t                     slot_r [DEPTH];
  logic [PW-1:0]              wr_r, wr_nxt, rd_r, rd_nxt;
  logic [$clog2(DEPTH+1)-1:0] cnt_r, cnt_nxt;

  // Advance pointers with wrap
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(DEPTH-1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(DEPTH-1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_entry;
    end
  end

  assign head      = slot_r[rd_r];
  assign not_empty = (cnt_r != '0);
  assign count     = cnt_r;

endmodule

/* design/fpc_back.sv */
// Resolver: picks the class from per-plane flags and holds the result register.
`timescale 1ns / 1ps
module fpc_back
  import fpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       not_empty,
  input  entry_t     head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_position_class
);

  logic out_valid_r;
  cls_t cls_r, cls_nxt;

  // First plane that stops the point test decides; any rejecting plane culls the box
  always_comb begin
    cls_nxt = CLS_BACK;
    unique case (head.op)
      OP_POINT: begin
        cls_nxt = CLS_BACK;
        for (int p = PLANE_COUNT-1; p >= 0; p--) begin
          if (head.dist_zero[p]) begin
            cls_nxt = CLS_ON_PLANE;
          end else if (head.dist_neg[p]) begin
            cls_nxt = CLS_FRONT;
          end
        end
      end
      OP_BOX: begin
        cls_nxt = (head.box_back != '0) ? CLS_BACK : CLS_SPANNING;
      end
      default: cls_nxt = CLS_BACK;
    endcase
  end

  assign pop = not_empty && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cls_r <= cls_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_position_class = cls_r;

endmodule

/* design/frustum_plane_classifier_top.sv */
// Top level of the frustum plane classifier: config registers, pipe, queue, resolver.
`timescale 1ns / 1ps
// Classifies one point or oriented box per cycle against six planes while in_stall is
// low. A transaction accepted on the input passes through four stages of multiply and
// compare arithmetic, a queue write, then the output register. A queue of QUEUE_DEPTH
// entries sits between the pipe and the output; the input stalls only when the queue
// together with items still in the pipe could fill it, so a steadily drained output
// sees one result per cycle. Plane registers must be written only while idle.
module frustum_plane_classifier_top
  import fpc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_op,
  input  logic signed [COORD_W-1:0] in_center_x,
  input  logic signed [COORD_W-1:0] in_center_y,
  input  logic signed [COORD_W-1:0] in_center_z,
  input  logic [PACK_W-1:0]         in_axis_zero,
  input  logic [PACK_W-1:0]         in_axis_one,
  input  logic [PACK_W-1:0]         in_axis_two,
  input  logic [PACK_W-1:0]         in_extents,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_position_class,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [PLANE_W-1:0]        cfg_data
);

  localparam int CW = $clog2(QUEUE_DEPTH + FRONT_STAGES + 1);

  logic [PLANE_COUNT-1:0][PLANE_W-1:0] planes_r;
  logic                                in_take;
  logic [$clog2(FRONT_STAGES+1)-1:0]   busy_cnt;
  logic                                q_push, q_pop, q_not_empty;
  entry_t                              q_push_entry, q_head;
  logic [$clog2(QUEUE_DEPTH+1)-1:0]    q_count;
  logic [CW-1:0]                       occupancy;

  // Hold plane registers; drop writes past the last plane
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      planes_r <= '0;
    end else if (cfg_valid && cfg_ready && (32'(cfg_index) < PLANE_COUNT)) begin
      planes_r[cfg_index] <= cfg_data;
    end
  end

  // Reserve queue room for everything already in flight
  assign occupancy = CW'(q_count) + CW'(busy_cnt);
  assign in_stall  = (occupancy >= CW'(QUEUE_DEPTH));
  assign in_take   = in_valid && !in_stall;

  fpc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .planes       (planes_r),
    .in_take      (in_take),
    .in_op        (in_op),
    .in_center_x  (in_center_x),
    .in_center_y  (in_center_y),
    .in_center_z  (in_center_z),
    .in_axis_zero (in_axis_zero),
    .in_axis_one  (in_axis_one),
    .in_axis_two  (in_axis_two),
    .in_extents   (in_extents),
    .busy_cnt     (busy_cnt),
    .push         (q_push),
    .push_entry   (q_push_entry)
  );

  fpc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head),
    .count      (q_count)
  );

  fpc_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .not_empty          (q_not_empty),
    .head               (q_head),
    .pop                (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_position_class (out_position_class)
  );

  // Queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && !q_pop |-> q_count < ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("queue overflow");

  // Pop only with data present
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty)
    else $error("queue underflow");

  // Credit bound holds
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    occupancy <= CW'(QUEUE_DEPTH))
    else $error("in-flight count exceeds queue depth");

  // Reset clears the output
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

/* tb/tb_frustum_plane_classifier_top.sv */
// Testbench for the frustum plane classifier: directed and random checks against a predictor.
`timescale 1ns / 1ps
module tb_frustum_plane_classifier_top;
  import fpc_pkg::*;

  localparam int  LIMIT_CYCLES = 400000;
  localparam int  DRAIN_CYCLES = 20;
  localparam logic [CFG_IDX_W-1:0] IDX_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] IDX_RIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] IDX_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] IDX_BOTTOM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] IDX_NEAR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] IDX_FAR    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE7 = 3'd7;

  typedef struct {
    op_t                op;
    logic [COORD_W-1:0] cx, cy, cz;
    logic [PACK_W-1:0]  ax0, ax1, ax2, ext;
  } volume_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_op = 1'b0;
  logic signed [COORD_W-1:0] in_center_x = '0, in_center_y = '0, in_center_z = '0;
  logic [PACK_W-1:0]         in_axis_zero = '0, in_axis_one = '0, in_axis_two = '0;
  logic [PACK_W-1:0]         in_extents = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [1:0]                out_position_class;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [PLANE_W-1:0]        cfg_data = '0;

  logic [PLANE_W-1:0] plane_regs [PLANE_COUNT];
  cls_t               class_fifo [$];
  int                 mismatches = 0;
  int                 cycle_count = 0;
  bit                 calm = 1'b0;

  frustum_plane_classifier_top i_dut (.*);

  always #5 clk = ~clk;

  // Sign-extend one 16-bit lane to 64 bits.
  function automatic longint lane16(logic [63:0] packed_val, int idx);
    logic [15:0] v;
    v = packed_val[16*idx +: 16];
    return longint'(signed'(v));
  endfunction

  function automatic longint plane_dist(logic [63:0] p, volume_t v);
    return lane16(p, 0) * longint'(signed'(v.cx)) + lane16(p, 1) * longint'(signed'(v.cy))
         + lane16(p, 2) * longint'(signed'(v.cz)) + lane16(p, 3) * 64'sd16384;
  endfunction

  function automatic longint axis_reach(logic [63:0] p, logic [PACK_W-1:0] axis, longint e);
    longint s;
    s = lane16(p, 0) * (lane16(axis, 0) * e) + lane16(p, 1) * (lane16(axis, 1) * e)
      + lane16(p, 2) * (lane16(axis, 2) * e);
    return s < 0 ? -s : s;
  endfunction

  // Compute the expected class for one volume against the current planes.
  function automatic cls_t classify_volume(volume_t v);
    longint d, r;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      d = plane_dist(plane_regs[i], v);
      if (v.op == OP_POINT) begin
        if (d == 0) return CLS_ON_PLANE;
        if (d < 0) return CLS_FRONT;
      end else begin
        r = axis_reach(plane_regs[i], v.ax0, lane16(v.ext, 0))
          + axis_reach(plane_regs[i], v.ax1, lane16(v.ext, 1))
          + axis_reach(plane_regs[i], v.ax2, lane16(v.ext, 2));
        if (d * 64'sd16384 <= -r) return CLS_BACK;
      end
    end
    return v.op == OP_POINT ? CLS_BACK : CLS_SPANNING;
  endfunction

  function automatic bit roll_idle();
    return !calm && ($urandom_range(99) < 24);
  endfunction

  // Send one transaction, with a random gap first.
  task automatic send_volume(volume_t v);
    cfg_valid <= 1'b0;
    while (roll_idle()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= v.op;
    in_center_x  <= v.cx;
    in_center_y  <= v.cy;
    in_center_z  <= v.cz;
    in_axis_zero <= v.ax0;
    in_axis_one  <= v.ax1;
    in_axis_two  <= v.ax2;
    in_extents   <= v.ext;
    class_fifo.push_back(classify_volume(v));
    do @(posedge clk); while (in_stall);
  endtask

  // Present one register write; valid stays high until the next send_volume drops it.
  task automatic write_plane(logic [CFG_IDX_W-1:0] idx, logic [PLANE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx < PLANE_COUNT) plane_regs[idx] = data;
  endtask

  // Hold until every expected result has arrived, then let the pipe settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (class_fifo.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] make_plane(int a, int b, int c, int d);
    return {d[15:0], c[15:0], b[15:0], a[15:0]};
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom_range(16'hFFFF)), $urandom()};
  endfunction

  // Random plane: mostly normals with lanes in [-16384, 16383], sometimes raw bits.
  function automatic logic [63:0] rand_plane();
    if ($urandom_range(3) == 0) return rand64();
    return make_plane($urandom_range(32767) - 16384, $urandom_range(32767) - 16384,
                      $urandom_range(32767) - 16384, $urandom_range(4095) - 2048);
  endfunction

  function automatic volume_t rand_volume();
    volume_t v;
    v.op = op_t'($urandom_range(1));
    if ($urandom_range(3) == 0) begin
      v.cx = 16'($urandom()); v.cy = 16'($urandom()); v.cz = 16'($urandom());
      v.ext = rand48();
    end else begin
      v.cx = 16'($urandom_range(4095) - 2048);
      v.cy = 16'($urandom_range(4095) - 2048);
      v.cz = 16'($urandom_range(4095) - 2048);
      v.ext = {16'($urandom_range(511)), 16'($urandom_range(511)), 16'($urandom_range(511))};
    end
    v.ax0 = rand48(); v.ax1 = rand48(); v.ax2 = rand48();
    return v;
  endfunction

  function automatic volume_t make_volume(op_t op, int x, int y, int z, logic [47:0] e);
    volume_t v;
    v.op = op; v.cx = 16'(x); v.cy = 16'(y); v.cz = 16'(z);
    v.ax0 = {16'd0, 16'd0, 16'h4000};
    v.ax1 = {16'd0, 16'h4000, 16'd0};
    v.ax2 = {16'h4000, 16'd0, 16'd0};
    v.ext = e;
    return v;
  endfunction

  task automatic load_planes(logic [63:0] p0, p1, p2, p3, p4, p5);
    write_plane(IDX_LEFT, p0);
    write_plane(IDX_RIGHT, p1);
    write_plane(IDX_TOP, p2);
    write_plane(IDX_BOTTOM, p3);
    write_plane(IDX_NEAR, p4);
    write_plane(IDX_FAR, p5);
  endtask

  // Zero planes after reset: points on_plane, boxes back.
  task automatic test_zero_planes();
    send_volume(make_volume(OP_POINT, 100, -5, 7, '0));
    send_volume(make_volume(OP_BOX, -32768, 32767, 0, '1));
    wait_idle();
  endtask

  // Axis-aligned cube frustum of half-width 1600 with field extremes.
  task automatic test_directed();
    load_planes(make_plane(16384, 0, 0, 1600), make_plane(-16384, 0, 0, 1600),
                make_plane(0, 16384, 0, 1600), make_plane(0, -16384, 0, 1600),
                make_plane(0, 0, 16384, 1600), make_plane(0, 0, -16384, 1600));
    send_volume(make_volume(OP_POINT, 0, 0, 0, '0));
    send_volume(make_volume(OP_POINT, -1600, 0, 0, '0));
    send_volume(make_volume(OP_POINT, -1601, 0, 0, '0));
    send_volume(make_volume(OP_POINT, 32767, 32767, 32767, '0));
    send_volume(make_volume(OP_POINT, -32768, -32768, -32768, '0));
    send_volume(make_volume(OP_BOX, -3200, 0, 0, {16'd10, 16'd10, 16'd1600}));
    send_volume(make_volume(OP_BOX, -3201, 0, 0, {16'd10, 16'd10, 16'd1600}));
    send_volume(make_volume(OP_BOX, 0, 0, 0, {16'd10, 16'd10, 16'd10}));
    // negative extents behave like positive ones
    send_volume(make_volume(OP_BOX, -3200, 0, 0, {16'hFFF6, 16'hFFF6, 16'hF9C0}));
    send_volume(make_volume(OP_BOX, 32767, -32768, 32767, 48'h8000_8000_8000));
    send_volume(make_volume(OP_BOX, 0, 0, 0, 48'h7FFF_7FFF_7FFF));
    wait_idle();
    // extreme plane values; spare indexes are ignored
    load_planes(64'h8000_8000_8000_8000, 64'h7FFF_7FFF_7FFF_7FFF, '1, '0,
                64'h8000_7FFF_8000_7FFF, 64'h7FFF_8000_7FFF_8000);
    write_plane(IDX_SPARE6, '1);
    write_plane(IDX_SPARE7, 64'h1234_5678_9ABC_DEF0);
    for (int i = 0; i < 6; i++) send_volume(rand_volume());
    wait_idle();
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 0) begin
        wait_idle();
        load_planes(rand_plane(), rand_plane(), rand_plane(), rand_plane(),
                    rand_plane(), rand_plane());
      end
      calm = (n >= 600 && n < 750);
      send_volume(rand_volume());
    end
    calm = 1'b0;
    wait_idle();
  endtask

  // Randomly stall the result channel.
  always @(posedge clk) out_stall <= roll_idle();

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (class_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", out_position_class);
      end else begin
        if (out_position_class !== class_fifo[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("class mismatch: expected %0d actual %0d", class_fifo[0],
                     out_position_class);
        end
        void'(class_fifo.pop_front());
      end
    end
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("** frustum_plane_classifier_top: FAILED **");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < PLANE_COUNT; i++) plane_regs[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_planes();
    test_directed();
    test_random(1200);
    if (mismatches == 0) begin
      $display("** frustum_plane_classifier_top: PASSED **");
    end else begin
      $display("** frustum_plane_classifier_top: FAILED **");
    end
    $finish;
  end

endmodule
